/* hw/rtl/oafe_pkg.sv */
// Package for the oscillating angle function evaluator: types, constants, tables.
`default_nettype none
package oafe_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int CORDIC_STAGES_MAX = 32;

  // Q.52 angle constants
  localparam logic signed [56:0] TWO_PI_Q52  = 57'sh06487ED5110B461;
  localparam logic signed [56:0] PI_Q52      = 57'sh03243F6A8885A31;
  localparam logic signed [56:0] HALF_PI_Q52 = 57'sh01921FB54442D18;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

  localparam logic signed [47:0] VAL_MAX = 48'sh7FFFFFFFFFFF;
  localparam logic signed [47:0] VAL_MIN = 48'sh800000000000;

  // register indexes
  localparam logic [1:0] REG_COS_CONST = 2'd0;
  localparam logic [1:0] REG_COS_SLOPE = 2'd1;
  localparam logic [1:0] REG_SIN_CONST = 2'd2;
  localparam logic [1:0] REG_SIN_SLOPE = 2'd3;

  // derivative orders
  localparam logic [2:0] ORD_0 = 3'd0;
  localparam logic [2:0] ORD_1 = 3'd1;
  localparam logic [2:0] ORD_2 = 3'd2;
  localparam logic [2:0] ORD_3 = 3'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] angle;
  } oafe_in_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic               order_error;
    logic               saturated;
  } oafe_out_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    begin
      case (i)
        0: r = 34'sh03243F6A8;
        1: r = 34'sh01DAC6705;
        2: r = 34'sh00FADBAFC;
        3: r = 34'sh007F56EA6;
        4: r = 34'sh003FEAB76;
        5: r = 34'sh001FFD55B;
        6: r = 34'sh000FFFAAA;
        7: r = 34'sh0007FFF55;
        8: r = 34'sh0003FFFEA;
        9: r = 34'sh0001FFFFD;
        10: r = 34'sh0000FFFFF;
        11: r = 34'sh00007FFFF;
        12: r = 34'sh00003FFFF;
        13: r = 34'sh00001FFFF;
        14: r = 34'sh00000FFFF;
        15: r = 34'sh000007FFF;
        16: r = 34'sh000003FFF;
        17: r = 34'sh000001FFF;
        18: r = 34'sh000000FFF;
        19: r = 34'sh0000007FF;
        20: r = 34'sh0000003FF;
        21: r = 34'sh0000001FF;
        22: r = 34'sh0000000FF;
        23: r = 34'sh00000007F;
        24: r = 34'sh00000003F;
        25: r = 34'sh00000001F;
        26: r = 34'sh00000000F;
        27: r = 34'sh000000007;
        28: r = 34'sh000000003;
        29: r = 34'sh000000001;
        default: r = '0;
      endcase
      atan_q30 = r;
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/oafe_cordic.sv */
// Pipelined rotation-mode CORDIC: angle reduction, one stage per iteration.
`default_nettype none
module oafe_cordic
  import oafe_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] angle,
  output logic                    out_valid,
  output logic signed [33:0]      cos_q30,
  output logic signed [33:0]      sin_q30
);

  // reduction stage 1: approximate turn count k = floor(t / 2pi)
  // |t| < 128 rad -> at most 21 turns; angle(Q.24) * (1/2pi in Q.16) -> Q.40, floor
  // the estimate is off by at most one turn
  logic signed [50:0] qprod;
  logic signed [6:0]  kq_next;
  logic signed [6:0]  kq;
  logic signed [31:0] ta;
  logic               v0;
  assign qprod = 51'(angle) * 51'sd10431;
  assign kq_next = 7'(qprod >>> 40);

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= in_valid;
    ta <= angle;
    kq <= kq_next;
  end

  // reduction stage 2: angle to Q.52 minus k turns, lands in [-2pi, 4pi)
  logic signed [56:0] t52;
  logic signed [56:0] r1_next;
  logic signed [56:0] r1;
  logic               v1;
  assign t52 = 57'(ta) <<< 28;
  always_comb begin
    r1_next = t52 - 57'(kq) * TWO_PI_Q52;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
    r1 <= r1_next;
  end

  // reduction stage 3: one turn of correction into [0, 2pi)
  logic signed [56:0] r2_next;
  logic signed [56:0] r2;
  logic               v2;
  always_comb begin
    if (r1 < 0) r2_next = r1 + TWO_PI_Q52;
    else if (r1 >= TWO_PI_Q52) r2_next = r1 - TWO_PI_Q52;
    else r2_next = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    r2 <= r2_next;
  end

  // reduction stage 4: move to (-pi, pi], fold to +-pi/2, round to Q.30
  logic signed [56:0] r2b, r2c;
  logic               neg2;
  logic signed [33:0] z2_next;
  logic signed [56:0] rnd;
  always_comb begin
    r2b = (r2 > PI_Q52) ? r2 - TWO_PI_Q52 : r2;
    neg2 = 1'b0;
    r2c = r2b;
    if (r2b > HALF_PI_Q52) begin
      r2c = r2b - PI_Q52;
      neg2 = 1'b1;
    end else if (r2b < -HALF_PI_Q52) begin
      r2c = r2b + PI_Q52;
      neg2 = 1'b1;
    end
    rnd = r2c + 57'sd2097152;
    z2_next = 34'(rnd >>> 22);
  end

  // CORDIC pipeline arrays, one entry per stage boundary
  logic signed [33:0] xs [CORDIC_STAGES+1];
  logic signed [33:0] ys [CORDIC_STAGES+1];
  logic signed [33:0] zs [CORDIC_STAGES+1];
  logic               ns [CORDIC_STAGES+1];
  logic               vs [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) vs[0] <= 1'b0;
    else vs[0] <= v2;
    xs[0] <= CORDIC_GAIN;
    ys[0] <= '0;
    zs[0] <= z2_next;
    ns[0] <= neg2;
  end

  // micro-rotation stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else vs[i+1] <= vs[i];
      ns[i+1] <= ns[i];
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q30(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q30(i);
      end
    end
  end

  // final sign fix
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vs[CORDIC_STAGES];
    cos_q30 <= ns[CORDIC_STAGES] ? -xs[CORDIC_STAGES] : xs[CORDIC_STAGES];
    sin_q30 <= ns[CORDIC_STAGES] ? -ys[CORDIC_STAGES] : ys[CORDIC_STAGES];
  end

`ifndef SYNTHESIS
  a_cos_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cos_q30 < 34'sh050000000 && cos_q30 > -34'sh050000000))
    else $error("cos out of range");
  a_sin_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sin_q30 < 34'sh050000000 && sin_q30 > -34'sh050000000))
    else $error("sin out of range");
  a_fold: assert property (@(posedge clk) disable iff (rst)
    v2 |=> (zs[0] <= 34'sh06487ED52 && zs[0] >= -34'sh06487ED52))
    else $error("reduced angle beyond pi/2");
`endif

endmodule
`default_nettype wire

/* hw/rtl/oscillating_angle_function_eval.sv */
// Top level: APB registers, coefficient path, CORDIC and combine pipeline.
`default_nettype none
// Evaluates the order-th derivative (0..3) of (A0+A1*t)cos t + (B0+B1*t)sin t.
// Fully pipelined: a new transaction may start every cycle (busy stays low) and
// each result appears one cycle long on done; the receiver cannot stall. The
// result path is the CORDIC pipeline, one stage per micro-rotation plus four
// angle-reduction stages and a sign-fix stage, followed by two combine stages
// and the output register. Coefficients must be written over APB only while no
// transaction is in flight; the block itself does not enforce this.
module oscillating_angle_function_eval
  import oafe_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire oafe_in_t    in_item,
  output logic             done,
  output oafe_out_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int LAT = CORDIC_STAGES + 4;

  logic signed [31:0] coef_cos_const, coef_cos_slope, coef_sin_const, coef_sin_slope;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_cos_const <= '0;
      coef_cos_slope <= '0;
      coef_sin_const <= '0;
      coef_sin_slope <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_COS_CONST: coef_cos_const <= pwdata;
        REG_COS_SLOPE: coef_cos_slope <= pwdata;
        REG_SIN_CONST: coef_sin_const <= pwdata;
        REG_SIN_SLOPE: coef_sin_slope <= pwdata;
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (paddr[3:2])
      REG_COS_CONST: prdata = coef_cos_const;
      REG_COS_SLOPE: prdata = coef_cos_slope;
      REG_SIN_CONST: prdata = coef_sin_const;
      REG_SIN_SLOPE: prdata = coef_sin_slope;
      default:       prdata = '0;
    endcase
  end

  logic in_fire;
  assign in_fire = start && !busy;

  // sine / cosine pipeline
  logic               cs_valid;
  logic signed [33:0] cos_q30, sin_q30;
  oafe_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst, .in_valid(in_fire), .angle(in_item.angle),
    .out_valid(cs_valid), .cos_q30, .sin_q30
  );

  // coefficient stage 1: slope products
  logic signed [63:0] pa1, pb1;
  logic [2:0]         m1;
  logic               cv1;
  always_ff @(posedge clk) begin
    if (rst) cv1 <= 1'b0;
    else cv1 <= in_fire;
    pa1 <= 64'(coef_cos_slope) * 64'(in_item.angle);
    pb1 <= 64'(coef_sin_slope) * 64'(in_item.angle);
    m1  <= in_item.mode;
  end

  // coefficient stage 2: round and form P, Q
  logic signed [63:0] ar, br;
  logic signed [42:0] a2, b2, a1x, b1x, p_next, q_next;
  always_comb begin
    ar  = (pa1 + 64'sd8388608) >>> 24;
    br  = (pb1 + 64'sd8388608) >>> 24;
    a2  = 43'(coef_cos_const) + 43'(ar);
    b2  = 43'(coef_sin_const) + 43'(br);
    a1x = 43'(coef_cos_slope);
    b1x = 43'(coef_sin_slope);
    case (m1)
      ORD_0: begin p_next = a2; q_next = b2; end
      ORD_1: begin p_next = a1x + b2; q_next = b1x - a2; end
      ORD_2: begin p_next = (b1x <<< 1) - a2; q_next = -((a1x <<< 1) + b2); end
      ORD_3: begin p_next = -(a1x * 43'sd3 + b2); q_next = a2 - b1x * 43'sd3; end
      default: begin p_next = '0; q_next = '0; end
    endcase
  end

  // P/Q delay line to meet the CORDIC output
  logic signed [42:0] pd [LAT];
  logic signed [42:0] qd [LAT];
  logic               ed [LAT];
  always_ff @(posedge clk) begin
    pd[0] <= p_next;
    qd[0] <= q_next;
    ed[0] <= m1[2];
  end
  for (genvar k = 1; k < LAT; k++) begin : g_dly
    always_ff @(posedge clk) begin
      pd[k] <= pd[k-1];
      qd[k] <= qd[k-1];
      ed[k] <= ed[k-1];
    end
  end

  // combine stage 1: four partial products (16-bit low halves, 27-bit high halves)
  logic signed [42:0] pp, qq;
  logic signed [26:0] ph, qh;
  logic signed [16:0] pl, ql;
  assign pp = pd[LAT-1];
  assign qq = qd[LAT-1];
  assign ph = pp[42:16];
  assign qh = qq[42:16];
  assign pl = {1'b0, pp[15:0]};
  assign ql = {1'b0, qq[15:0]};

  logic signed [63:0] hpc, hqs, lpc, lqs;
  logic               e3, v3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= cs_valid;
    hpc <= 64'(ph) * 64'(cos_q30);
    hqs <= 64'(qh) * 64'(sin_q30);
    lpc <= 64'(pl) * 64'(cos_q30);
    lqs <= 64'(ql) * 64'(sin_q30);
    e3  <= ed[LAT-1];
  end

  // combine stage 2: sums and round
  logic signed [63:0] lo, vsum;
  logic signed [63:0] v4;
  logic               e4, val4;
  always_comb begin
    lo   = lpc + lqs + 64'sd536870912;
    vsum = (hpc + hqs + (lo >>> 16)) >>> 14;
  end
  always_ff @(posedge clk) begin
    if (rst) val4 <= 1'b0;
    else val4 <= v3;
    v4 <= vsum;
    e4 <= e3;
  end

  // output: flag order errors, saturate and strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= val4;
    if (e4) begin
      out_item.value <= '0;
      out_item.order_error <= 1'b1;
      out_item.saturated <= 1'b0;
    end else if (v4 > 64'(VAL_MAX)) begin
      out_item.value <= VAL_MAX;
      out_item.order_error <= 1'b0;
      out_item.saturated <= 1'b1;
    end else if (v4 < 64'(VAL_MIN)) begin
      out_item.value <= VAL_MIN;
      out_item.order_error <= 1'b0;
      out_item.saturated <= 1'b1;
    end else begin
      out_item.value <= 48'(v4);
      out_item.order_error <= 1'b0;
      out_item.saturated <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_align: assert property (@(posedge clk) disable iff (rst)
    cs_valid |-> $past(cv1, LAT))
    else $error("coefficient path misaligned with CORDIC");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_item.order_error) |-> (out_item.value == '0 && !out_item.saturated))
    else $error("order error with nonzero value");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> ##(LAT+4) done)
    else $error("result latency broken");
`endif

endmodule
`default_nettype wire
